[sv/spmlq_pkg.sv]
package spmlq_pkg;

    localparam int CMD_W    = 2;
    localparam int PRIO_W   = 8;
    localparam int TAG_W    = 32;
    localparam int STATUS_W = 2;
    localparam int LEVEL_W  = 4;
    localparam int COUNT_W  = 7;
    localparam int MAXP_W   = 4;

    localparam int LEVELS_DEF     = 16;
    localparam int POOL_DEPTH_DEF = 64;

    localparam logic [CMD_W-1:0] CMD_ENQUEUE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DEQUEUE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FRONT   = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_INVALID = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

    localparam logic [MAXP_W-1:0] MAXP_RESET = 4'd15;

endpackage

[sv/spmlq_req_if.sv]
interface spmlq_req_if import spmlq_pkg::*; ();

    logic                valid;
    logic                ready;
    logic [CMD_W-1:0]    command;
    logic [PRIO_W-1:0]   priority_req;
    logic [TAG_W-1:0]    request_tag;

    modport source (output valid, command, priority_req, request_tag, input ready);
    modport sink   (input valid, command, priority_req, request_tag, output ready);

endinterface

[sv/spmlq_rsp_if.sv]
interface spmlq_rsp_if import spmlq_pkg::*; ();

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic                item_valid;
    logic [TAG_W-1:0]    item_tag;
    logic [LEVEL_W-1:0]  item_level;
    logic [COUNT_W-1:0]  entry_count;

    modport source (output valid, status, item_valid, item_tag, item_level, entry_count,
                    input ready);
    modport sink   (input valid, status, item_valid, item_tag, item_level, entry_count,
                    output ready);

endinterface

[sv/strict_priority_multilevel_queue.sv]
// Strict priority queue: one linked-list fifo per level in a shared slot pool.
// i_req carries a word {command, priority_req, request_tag}; command 0 enqueues,
// 1 dequeues the oldest entry of the highest nonempty level, 2 peeks at it.
// o_rsp returns one word per request {status, item_valid, item_tag, item_level,
// entry_count}. i_cfg_we / i_cfg_wdata write max_priority; the user must do so
// only while the block is idle, as the block itself does not enforce it.
// Enqueue and rejected requests pass through the level table read (head and
// tail pointers); dequeue and front that return an entry add the dependent slot
// memory read of tag and link. One request is in work at a time; a new one is
// accepted once the previous result sits in the output register.
// Reset (synchronous, active low) empties all levels, rewinds the free list and
// sets max_priority to 15; unused slots are handed out through a fill count, so
// there is no clearing pass and requests are taken right after reset.
// If the receiver stalls, the result holds in the output register; the next
// request is accepted and worked up to its result, which waits for the register.
module strict_priority_multilevel_queue import spmlq_pkg::*; #(
    parameter int LEVELS     = LEVELS_DEF,
    parameter int POOL_DEPTH = POOL_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    spmlq_req_if.sink          i_req,
    spmlq_rsp_if.source        o_rsp,
    input  logic               i_cfg_we,
    input  logic [MAXP_W-1:0]  i_cfg_wdata
);

    localparam int PW   = $clog2(POOL_DEPTH);
    localparam int LW   = $clog2(LEVELS);
    localparam int CW   = $clog2(POOL_DEPTH + 1);
    localparam int SCAN = (LEVELS < (2 ** MAXP_W)) ? LEVELS : (2 ** MAXP_W);
    localparam logic [PRIO_W:0] TOP_LVL = (PRIO_W + 1)'(LEVELS - 1);
    localparam logic [PW-1:0]   LAST_SLOT = PW'(POOL_DEPTH - 1);
    localparam logic [CW-1:0]   FULL_CNT  = CW'(POOL_DEPTH);

    typedef enum logic [1:0] {S_IDLE, S_LVL, S_SLOT} t_state;

    t_state              r_state, n_state;
    logic [CMD_W-1:0]    r_cmd, n_cmd;
    logic [TAG_W-1:0]    r_tag, n_tag;
    logic [LW-1:0]       r_lvl, n_lvl;
    logic                r_act, n_act;
    logic [STATUS_W-1:0] r_status, n_status;
    logic                r_fresh_hit, n_fresh_hit;
    logic [PW-1:0]       r_next_fresh, n_next_fresh;
    logic [CW-1:0]       r_count, n_count;
    logic [CW-1:0]       r_fresh, n_fresh;
    logic [PW-1:0]       r_free_head, n_free_head;
    logic [LEVELS-1:0]   r_nonempty, n_nonempty;
    logic [MAXP_W-1:0]   r_max, n_max;

    logic                r_out_valid, n_out_valid;
    logic [STATUS_W-1:0] r_out_status, n_out_status;
    logic                r_out_item_valid, n_out_item_valid;
    logic [TAG_W-1:0]    r_out_tag, n_out_tag;
    logic [LEVEL_W-1:0]  r_out_level, n_out_level;
    logic [COUNT_W-1:0]  r_out_count, n_out_count;

    logic [MAXP_W-1:0]   eff_max;
    logic                found;
    logic [MAXP_W-1:0]   found_lvl;
    logic                out_free;
    logic [PW-1:0]       head, tail;

    logic                lvl_we, lvl_re;
    logic [LW-1:0]       lvl_waddr, lvl_raddr;
    logic [2*PW-1:0]     lvl_wdata, lvl_rdata;
    logic                link_we, link_re;
    logic [PW-1:0]       link_waddr, link_raddr, link_wdata, link_rdata;
    logic                tag_we, tag_re;
    logic [PW-1:0]       tag_waddr, tag_raddr;
    logic [TAG_W-1:0]    tag_wdata, tag_rdata;

    spmlq_ram #(.WIDTH(2 * PW), .DEPTH(LEVELS)) u_level_ram (
        .i_clk   (i_clk),
        .i_we    (lvl_we),
        .i_waddr (lvl_waddr),
        .i_wdata (lvl_wdata),
        .i_re    (lvl_re),
        .i_raddr (lvl_raddr),
        .o_rdata (lvl_rdata)
    );

    spmlq_ram #(.WIDTH(PW), .DEPTH(POOL_DEPTH)) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (link_we),
        .i_waddr (link_waddr),
        .i_wdata (link_wdata),
        .i_re    (link_re),
        .i_raddr (link_raddr),
        .o_rdata (link_rdata)
    );

    spmlq_ram #(.WIDTH(TAG_W), .DEPTH(POOL_DEPTH)) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (tag_we),
        .i_waddr (tag_waddr),
        .i_wdata (tag_wdata),
        .i_re    (tag_re),
        .i_raddr (tag_raddr),
        .o_rdata (tag_rdata)
    );

    assign head     = lvl_rdata[2*PW-1:PW];
    assign tail     = lvl_rdata[PW-1:0];
    assign out_free = !r_out_valid || o_rsp.ready;

    assign i_req.ready       = (r_state == S_IDLE);
    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_out_status;
    assign o_rsp.item_valid  = r_out_item_valid;
    assign o_rsp.item_tag    = r_out_tag;
    assign o_rsp.item_level  = r_out_level;
    assign o_rsp.entry_count = r_out_count;

    // effective max level and highest nonempty level at or below it
    always_comb begin
        if ({{(PRIO_W + 1 - MAXP_W){1'b0}}, r_max} > TOP_LVL) begin
            eff_max = TOP_LVL[MAXP_W-1:0];
        end else begin
            eff_max = r_max;
        end
        found     = 1'b0;
        found_lvl = '0;
        for (int k = 0; k < SCAN; k++) begin
            if (r_nonempty[k] && (MAXP_W'(k) <= eff_max)) begin
                found     = 1'b1;
                found_lvl = MAXP_W'(k);
            end
        end
    end

    always_comb begin
        n_state      = r_state;
        n_cmd        = r_cmd;
        n_tag        = r_tag;
        n_lvl        = r_lvl;
        n_act        = r_act;
        n_status     = r_status;
        n_fresh_hit  = r_fresh_hit;
        n_next_fresh = r_next_fresh;
        n_count      = r_count;
        n_fresh      = r_fresh;
        n_free_head  = r_free_head;
        n_nonempty   = r_nonempty;
        n_max        = r_max;

        n_out_valid      = r_out_valid && !o_rsp.ready;
        n_out_status     = r_out_status;
        n_out_item_valid = r_out_item_valid;
        n_out_tag        = r_out_tag;
        n_out_level      = r_out_level;
        n_out_count      = r_out_count;

        lvl_we     = 1'b0;
        lvl_waddr  = r_lvl;
        lvl_wdata  = lvl_rdata;
        lvl_re     = 1'b0;
        lvl_raddr  = r_lvl;
        link_we    = 1'b0;
        link_waddr = tail;
        link_wdata = r_free_head;
        link_re    = 1'b0;
        link_raddr = r_free_head;
        tag_we     = 1'b0;
        tag_waddr  = r_free_head;
        tag_wdata  = r_tag;
        tag_re     = 1'b0;
        tag_raddr  = head;

        if (i_cfg_we) begin
            n_max = i_cfg_wdata;
        end

        case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_cmd        = i_req.command;
                    n_tag        = i_req.request_tag;
                    n_act        = 1'b0;
                    n_lvl        = '0;
                    n_fresh_hit  = ({{(CW - PW){1'b0}}, r_free_head} == r_fresh);
                    n_next_fresh = (r_free_head == LAST_SLOT) ? '0 : r_free_head + PW'(1);
                    if (i_req.command == CMD_ENQUEUE) begin
                        n_lvl = i_req.priority_req[LW-1:0];
                        if ((i_req.request_tag == '0) ||
                            (i_req.priority_req > {{(PRIO_W - MAXP_W){1'b0}}, eff_max})) begin
                            n_status = ST_INVALID;
                        end else if (r_count >= FULL_CNT) begin
                            n_status = ST_FULL;
                        end else begin
                            n_status = ST_OK;
                            n_act    = 1'b1;
                        end
                    end else if ((i_req.command == CMD_DEQUEUE) ||
                                 (i_req.command == CMD_FRONT)) begin
                        n_lvl = LW'(found_lvl);
                        if (r_count == '0) begin
                            n_status = ST_EMPTY;
                        end else if (!found) begin
                            n_status = (i_req.command == CMD_DEQUEUE) ? ST_OK : ST_EMPTY;
                        end else begin
                            n_status = ST_OK;
                            n_act    = 1'b1;
                        end
                    end else begin
                        n_status = ST_INVALID;
                    end
                    lvl_re     = 1'b1;
                    lvl_raddr  = n_lvl;
                    link_re    = 1'b1;
                    link_raddr = r_free_head;
                    n_state    = S_LVL;
                end
            end

            S_LVL: begin
                if (r_act && (r_cmd != CMD_ENQUEUE)) begin
                    tag_re     = 1'b1;
                    tag_raddr  = head;
                    link_re    = 1'b1;
                    link_raddr = head;
                    n_state    = S_SLOT;
                end else if (out_free) begin
                    if (r_act) begin
                        n_free_head = r_fresh_hit ? r_next_fresh : link_rdata;
                        if (r_fresh_hit) begin
                            n_fresh = r_fresh + CW'(1);
                        end
                        tag_we    = 1'b1;
                        tag_waddr = r_free_head;
                        tag_wdata = r_tag;
                        lvl_we    = 1'b1;
                        lvl_waddr = r_lvl;
                        if (r_nonempty[r_lvl]) begin
                            link_we    = 1'b1;
                            link_waddr = tail;
                            link_wdata = r_free_head;
                            lvl_wdata  = {head, r_free_head};
                        end else begin
                            lvl_wdata  = {r_free_head, r_free_head};
                        end
                        n_nonempty[r_lvl] = 1'b1;
                        n_count = r_count + CW'(1);
                    end
                    n_out_valid      = 1'b1;
                    n_out_status     = r_status;
                    n_out_item_valid = 1'b0;
                    n_out_tag        = '0;
                    n_out_level      = '0;
                    n_out_count      = COUNT_W'(n_count);
                    n_state          = S_IDLE;
                end
            end

            S_SLOT: begin
                if (out_free) begin
                    if (r_cmd == CMD_DEQUEUE) begin
                        if (head == tail) begin
                            n_nonempty[r_lvl] = 1'b0;
                        end else begin
                            lvl_we    = 1'b1;
                            lvl_waddr = r_lvl;
                            lvl_wdata = {link_rdata, tail};
                        end
                        link_we     = 1'b1;
                        link_waddr  = head;
                        link_wdata  = r_free_head;
                        n_free_head = head;
                        n_count     = r_count - CW'(1);
                    end
                    n_out_valid      = 1'b1;
                    n_out_status     = ST_OK;
                    n_out_item_valid = 1'b1;
                    n_out_tag        = tag_rdata;
                    n_out_level      = LEVEL_W'(r_lvl);
                    n_out_count      = COUNT_W'(n_count);
                    n_state          = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_fresh     <= '0;
            r_free_head <= '0;
            r_nonempty  <= '0;
            r_max       <= MAXP_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_fresh     <= n_fresh;
            r_free_head <= n_free_head;
            r_nonempty  <= n_nonempty;
            r_max       <= n_max;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd            <= n_cmd;
        r_tag            <= n_tag;
        r_lvl            <= n_lvl;
        r_act            <= n_act;
        r_status         <= n_status;
        r_fresh_hit      <= n_fresh_hit;
        r_next_fresh     <= n_next_fresh;
        r_out_status     <= n_out_status;
        r_out_item_valid <= n_out_item_valid;
        r_out_tag        <= n_out_tag;
        r_out_level      <= n_out_level;
        r_out_count      <= n_out_count;
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count <= FULL_CNT) && (r_fresh <= FULL_CNT))
        else $error("entry count or fill count beyond pool depth");

    a_empty_levels: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_nonempty == '0))
        else $error("level marked nonempty with no entries held");

    a_item_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.item_valid) |-> (o_rsp.status == ST_OK))
        else $error("item returned with failing status");

    a_one_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !i_req.ready)
        else $error("request accepted while another is in work");
`endif

endmodule

[sv/spmlq_ram.sv]
module spmlq_ram import spmlq_pkg::*; #(
    parameter int WIDTH = TAG_W,
    parameter int DEPTH = POOL_DEPTH_DEF,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
